// File: rtl/rsnh_pkg.sv
// Package for the ray/sphere nearest-hit unit: widths, request kinds, register indexes and
// the channel and queue entry types. Used by every module of the block and by the testbench.
package rsnh_pkg;

   localparam int COORD_W = 32;
   localparam int DIR_W   = 16;
   localparam int DIST_W  = 31;
   localparam int DIR_FRAC = 14;
   localparam int ID_WIDTH = 16;
   // oc is 33 bits, oc*dir is 49 bits, the three-term sum 51 bits.
   localparam int OC_W    = 33;
   localparam int PROD_W  = 49;
   localparam int DOT_W   = 51;
   localparam int B_W     = 37;
   localparam int MAG_W   = 37;
   localparam int SQ_W    = 76;
   localparam int SQRT_W  = 38;

   // Configuration register indexes.
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X    = 3'd3;
   localparam logic [2:0] REG_DIR_Y    = 3'd4;
   localparam logic [2:0] REG_DIR_Z    = 3'd5;

   typedef enum logic {
      KIND_TEST  = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DOT,
      FE_SQ,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_SQRT,
      BE_DONE
   } be_state_type;

   // One sphere test or clear request.
   typedef struct packed {
      kind_type                  kind;
      logic [ID_WIDTH-1:0]       object_id;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [DIST_W-1:0]         sphere_radius;
   } req_type;

   // One result.
   typedef struct packed {
      logic                hit;
      logic [1:0]          root_count;
      logic [DIST_W-1:0]   hit_distance;
      logic                is_nearest;
      logic                nearest_valid;
      logic [ID_WIDTH-1:0] nearest_id;
   } rsp_type;

   // One classified request on its way from front to back.
   typedef struct packed {
      logic              clear;
      logic [1:0]        roots;
      logic signed [B_W-1:0] b;
      logic [SQ_W-1:0]   delta;
      logic [ID_WIDTH-1:0] id;
   } job_type;

endpackage

// File: rtl/rsnh_if.sv
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing; the payload type is a parameter.
interface rsnh_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rsnh_front.sv
// Front part: forms oc, the rounded dot product b and the discriminant, and classifies it.
// Depends on rsnh_pkg.
module rsnh_front
   import rsnh_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      in_kind,
   input  logic [ID_WIDTH-1:0]       in_id,
   input  logic signed [COORD_W-1:0] in_cx,
   input  logic signed [COORD_W-1:0] in_cy,
   input  logic signed [COORD_W-1:0] in_cz,
   input  logic [DIST_W-1:0]         in_r,
   input  logic signed [COORD_W-1:0] org_x,
   input  logic signed [COORD_W-1:0] org_y,
   input  logic signed [COORD_W-1:0] org_z,
   input  logic signed [DIR_W-1:0]   dir_x,
   input  logic signed [DIR_W-1:0]   dir_y,
   input  logic signed [DIR_W-1:0]   dir_z,
   output logic                      job_valid,
   input  logic                      job_ready,
   output job_type                   job
);

   fe_state_type state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic                 clear_ff;
   logic [ID_WIDTH-1:0]  id_ff;
   logic signed [OC_W-1:0] oc_ff [3];
   logic [DIST_W-1:0]    r_ff;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [SQ_W-1:0]      pos_ff, pos_in, neg_ff, neg_in;
   logic signed [B_W-1:0] b_ff;
   logic signed [PROD_W-1:0] prod;
   logic signed [OC_W-1:0] oc_sel;
   logic signed [DIR_W-1:0] dir_sel;
   logic [MAG_W-1:0]     sq_a, sq_b;
   logic [SQ_W-1:0]      sq_p;
   logic signed [B_W-1:0] b_rnd;

   // One multiplier for the dot product, one squarer shared over four terms.
   always_comb begin
      oc_sel  = oc_ff[step_ff];
      dir_sel = (step_ff == 2'd0) ? dir_x : (step_ff == 2'd1) ? dir_y : dir_z;
      prod    = PROD_W'(oc_sel * dir_sel);
      unique case (step_ff)
         2'd0: sq_a = MAG_W'(oc_ff[0][OC_W-1] ? -oc_ff[0] : oc_ff[0]);
         2'd1: sq_a = MAG_W'(oc_ff[1][OC_W-1] ? -oc_ff[1] : oc_ff[1]);
         2'd2: sq_a = MAG_W'(oc_ff[2][OC_W-1] ? -oc_ff[2] : oc_ff[2]);
         default: sq_a = b_ff[B_W-1] ? MAG_W'(-b_ff) : MAG_W'(b_ff);
      endcase
      sq_b = MAG_W'(r_ff);
      sq_p = SQ_W'(sq_a * sq_a);
   end

   // The accumulator starts at the rounding bias, so b is the complete sum shifted down.
   assign b_rnd = B_W'(dot_in >>> DIR_FRAC);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dot_in   = dot_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      in_ready = 1'b0;
      job_valid = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            in_ready = 1'b1;
            step_in  = 2'd0;
            dot_in   = DOT_W'(1 << (DIR_FRAC-1));
            neg_in   = '0;
            if (in_valid) state_in = (in_kind == KIND_CLEAR) ? FE_PUSH : FE_DOT;
         end
         FE_DOT: begin
            dot_in  = dot_ff + DOT_W'(prod);
            neg_in  = neg_ff + sq_p;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = FE_SQ;
               step_in  = 2'd3;
            end
         end
         FE_SQ: begin
            pos_in = sq_p + SQ_W'(sq_b * sq_b);
            state_in = FE_PUSH;
         end
         FE_PUSH: begin
            job_valid = 1'b1;
            if (job_ready) state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      dot_ff  <= dot_in;
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
      if (state_ff == FE_DOT && step_ff == 2'd2) b_ff <= b_rnd;
      if (state_ff == FE_IDLE && in_valid) begin
         clear_ff <= in_kind;
         id_ff    <= in_id;
         oc_ff[0] <= OC_W'(org_x) - OC_W'(in_cx);
         oc_ff[1] <= OC_W'(org_y) - OC_W'(in_cy);
         oc_ff[2] <= OC_W'(org_z) - OC_W'(in_cz);
         r_ff     <= in_r;
      end
   end

   // Classification of the discriminant.
   always_comb begin
      job.clear = clear_ff;
      job.b     = b_ff;
      job.id    = id_ff;
      job.delta = pos_ff - neg_ff;
      if (clear_ff || pos_ff < neg_ff) job.roots = 2'd0;
      else if (pos_ff == neg_ff)       job.roots = 2'd1;
      else                             job.roots = 2'd2;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> state_ff == FE_IDLE) else $error("front ready outside idle");
   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid) else $error("front dropped job");
   a_sq_after_dot: assert property (@(posedge clock) disable iff (reset)
      state_ff == FE_SQ |-> $past(state_ff) == FE_DOT) else $error("front order");

endmodule

// File: rtl/rsnh_queue.sv
// Two-entry queue between front and back parts.
// Depends on rsnh_pkg.
module rsnh_queue
   import rsnh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type mem_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wr_ff == rd_ff) else $error("queue ptr");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |=> !(($past(pop)))) else $error("queue popped empty");

endmodule

// File: rtl/rsnh_back.sv
// Back part: bit-serial square root, nearest root selection and nearest-hit record.
// Depends on rsnh_pkg.
module rsnh_back
   import rsnh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  job_type             job,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_hit,
   output logic [1:0]          out_roots,
   output logic [DIST_W-1:0]   out_dist,
   output logic                out_nearest,
   output logic                out_nvalid,
   output logic [ID_WIDTH-1:0] out_nid
);

   be_state_type state_ff, state_in;
   job_type      job_ff;
   logic [SQ_W-1:0]   rem_ff, rem_in;
   logic [SQRT_W-1:0] root_ff, root_in;
   logic [5:0]        bit_ff, bit_in;
   logic [DIST_W-1:0] best_dist_ff;
   logic              best_valid_ff;
   logic [ID_WIDTH-1:0] best_id_ff;
   logic              out_valid_ff, out_hit_ff, out_nearest_ff, out_nvalid_ff;
   logic [1:0]        out_roots_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic [ID_WIDTH-1:0] out_nid_ff;
   logic [SQ_W+1:0]   trial;
   logic signed [B_W+1:0] nb, d1, d2, dsel;
   logic found;
   logic [DIST_W-1:0] dsat;
   logic load, take;

   // Restoring square root, one result bit a cycle.
   always_comb begin
      trial = ((SQ_W+2)'(root_ff) << (bit_ff + 6'd1)) +
              ((SQ_W+2)'(1) << (7'(bit_ff) << 1));
   end

   always_comb begin
      nb = -(B_W+2)'(job_ff.b);
      d1 = nb + (B_W+2)'(root_ff);
      d2 = nb - (B_W+2)'(root_ff);
      found = 1'b0;
      dsel  = '0;
      if (!job_ff.clear) begin
         if (job_ff.roots == 2'd1) begin
            found = !nb[B_W+1];
            dsel  = nb;
         end else if (job_ff.roots == 2'd2) begin
            if (!d2[B_W+1]) begin
               found = 1'b1; dsel = d2;
            end else if (!d1[B_W+1]) begin
               found = 1'b1; dsel = d1;
            end
         end
      end
      dsat = (dsel > (B_W+2)'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : dsel[DIST_W-1:0];
   end

   // A result is registered when the output register is free; a closer hit takes the record.
   assign load = (state_ff == BE_DONE) && (!out_valid_ff || out_ready);
   assign take = found && (!best_valid_ff || dsat < best_dist_ff);

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      job_ready = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            job_ready = 1'b1;
            rem_in  = job.delta;
            root_in = '0;
            bit_in  = 6'(SQRT_W-1);
            if (job_valid) state_in = (job.roots == 2'd2) ? BE_SQRT : BE_DONE;
         end
         BE_SQRT: begin
            if (trial <= (SQ_W+2)'(rem_ff)) begin
               rem_in  = rem_ff - SQ_W'(trial);
               root_in = root_ff | (SQRT_W'(1) << bit_ff);
            end
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) state_in = BE_DONE;
         end
         BE_DONE: begin
            if (!out_valid_ff || out_ready) state_in = BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   // Record update and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BE_IDLE;
         out_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         best_dist_ff  <= '0;
         best_id_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (load) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
         if (load && job_ff.clear) begin
            best_valid_ff <= 1'b0;
            best_dist_ff  <= '0;
            best_id_ff    <= '0;
         end else if (load && take) begin
            best_valid_ff <= 1'b1;
            best_dist_ff  <= dsat;
            best_id_ff    <= job_ff.id;
         end
      end
      if (load) begin
         out_hit_ff     <= found;
         out_roots_ff   <= job_ff.roots;
         out_dist_ff    <= found ? dsat : '0;
         out_nearest_ff <= take;
         out_nvalid_ff  <= job_ff.clear ? 1'b0 : (take || best_valid_ff);
         out_nid_ff     <= job_ff.clear ? '0 : (take ? job_ff.id : best_id_ff);
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (state_ff == BE_IDLE && job_valid) job_ff <= job;
   end

   assign out_valid   = out_valid_ff;
   assign out_hit     = out_hit_ff;
   assign out_roots   = out_roots_ff;
   assign out_dist    = out_dist_ff;
   assign out_nearest = out_nearest_ff;
   assign out_nvalid  = out_nvalid_ff;
   assign out_nid     = out_nid_ff;

   a_nearest_hit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_nearest_ff |-> out_hit_ff && out_nvalid_ff)
      else $error("nearest w/o hit");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_hit_ff |-> out_dist_ff == '0) else $error("miss distance");
   a_hit_roots: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_hit_ff |-> out_roots_ff != 2'd0) else $error("hit without roots");

endmodule

// File: rtl/ray_sphere_nearest_hit_top.sv
// Top level of the ray/sphere nearest-hit unit: configuration registers and the three parts.
// Depends on rsnh_pkg, rsnh_if, rsnh_front, rsnh_queue and rsnh_back.
//
// The unit tests spheres against one ray held in six configuration registers and keeps the
// nearest hit since the last clear request. A request is accepted only while the front part
// is idle. A crossing sphere passes through the front part (three dot-product steps, one for
// the squares and one to hand the job to the queue), then the back part takes the job, runs 38
// square-root iterations and registers the result. A request with fewer than two roots skips
// the square root, and a clear also skips the dot product and the squares. The back part
// takes no new job until it has registered the result of the last one; meanwhile the front
// part and the two-entry queue can hold three more requests. Write the configuration only
// while no request is in flight.
module ray_sphere_nearest_hit_top
   import rsnh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rsnh_if.sink        req,
   rsnh_if.source      rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic signed [COORD_W-1:0] ox_ff, oy_ff, oz_ff;
   logic signed [DIR_W-1:0]   dx_ff, dy_ff, dz_ff;
   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         dx_ff <= '0; dy_ff <= '0; dz_ff <= 16'shC000;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X: ox_ff <= csr_wdata;
            REG_ORIGIN_Y: oy_ff <= csr_wdata;
            REG_ORIGIN_Z: oz_ff <= csr_wdata;
            REG_DIR_X:    dx_ff <= csr_wdata[DIR_W-1:0];
            REG_DIR_Y:    dy_ff <= csr_wdata[DIR_W-1:0];
            REG_DIR_Z:    dz_ff <= csr_wdata[DIR_W-1:0];
            default: ;
         endcase
      end
   end

   rsnh_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_kind(req.data.kind), .in_id(req.data.object_id),
      .in_cx(req.data.center_x), .in_cy(req.data.center_y), .in_cz(req.data.center_z),
      .in_r(req.data.sphere_radius),
      .org_x(ox_ff), .org_y(oy_ff), .org_z(oz_ff),
      .dir_x(dx_ff), .dir_y(dy_ff), .dir_z(dz_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   rsnh_queue u_queue (
      .clock, .reset,
      .push_valid(fj_valid), .push_ready(fj_ready), .push_data(fj),
      .pop_valid(bj_valid), .pop_ready(bj_ready), .pop_data(bj)
   );

   rsnh_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_hit(rsp.data.hit), .out_roots(rsp.data.root_count),
      .out_dist(rsp.data.hit_distance), .out_nearest(rsp.data.is_nearest),
      .out_nvalid(rsp.data.nearest_valid), .out_nid(rsp.data.nearest_id)
   );

endmodule

// File: tb/sv/ray_sphere_nearest_hit_top_tb.sv
// Testbench for the ray/sphere nearest-hit unit: directed and random sphere requests, checked
// against an in-bench predictor of the hit distance and of the nearest-hit record.
// Depends on rsnh_pkg, rsnh_if and ray_sphere_nearest_hit_top.
module ray_sphere_nearest_hit_top_tb;
   import rsnh_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam logic signed [15:0] DIR_ONE = 16'sd16384;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   rsnh_if #(.payload_type(req_type)) req_ch ();
   rsnh_if #(.payload_type(rsp_type)) rsp_ch ();

   ray_sphere_nearest_hit_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the ray and of the nearest-hit record.
   logic signed [31:0] ray_org_x, ray_org_y, ray_org_z;
   logic signed [15:0] ray_dir_x, ray_dir_y, ray_dir_z;
   logic [30:0]        rec_distance;
   logic               rec_valid;
   logic [15:0]        rec_id;

   rsp_type     expected_hits[$];
   int          mismatch_count = 0;
   int          results_seen = 0;
   int          hits_seen = 0;
   int          tangents_seen = 0;
   longint      cycle_count = 0;
   bit          ready_always = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic longint abs_val(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Works out one result and updates the nearest-hit record.
   function automatic rsp_type trace_sphere(req_type s);
      rsp_type      res;
      longint       ocx, ocy, ocz, bq, b, nb, d, root;
      logic [127:0] pos, neg, delta;
      logic [63:0]  acc, trial;
      logic [30:0]  dsat;
      bit           found;
      res = '0;
      found = 1'b0;
      d = 0;
      if (s.kind == KIND_CLEAR) begin
         rec_distance = '0;
         rec_valid = 1'b0;
         rec_id = '0;
         return res;
      end
      ocx = longint'(ray_org_x) - longint'(s.center_x);
      ocy = longint'(ray_org_y) - longint'(s.center_y);
      ocz = longint'(ray_org_z) - longint'(s.center_z);
      bq = longint'(ray_dir_x) * ocx + longint'(ray_dir_y) * ocy
         + longint'(ray_dir_z) * ocz;
      // Round Q.30 to Q16.16, ties toward plus infinity.
      b = (bq + 8192) >>> DIR_FRAC;
      nb = -b;
      pos = 128'(abs_val(b)) * 128'(abs_val(b))
          + 128'(s.sphere_radius) * 128'(s.sphere_radius);
      neg = 128'(abs_val(ocx)) * 128'(abs_val(ocx))
          + 128'(abs_val(ocy)) * 128'(abs_val(ocy))
          + 128'(abs_val(ocz)) * 128'(abs_val(ocz));
      if (pos == neg) begin
         res.root_count = 2'd1;
         if (nb >= 0) begin
            found = 1'b1;
            d = nb;
         end
      end else if (pos > neg) begin
         delta = pos - neg;
         acc = '0;
         for (int k = 37; k >= 0; k--) begin
            trial = acc | (64'd1 << k);
            if (128'(trial) * 128'(trial) <= delta) acc = trial;
         end
         root = longint'(acc);
         res.root_count = 2'd2;
         if (nb - root >= 0) begin
            found = 1'b1;
            d = nb - root;
         end else if (nb + root >= 0) begin
            found = 1'b1;
            d = nb + root;
         end
      end
      if (found) begin
         dsat = (d > 64'sh7FFFFFFF) ? 31'h7FFFFFFF : d[30:0];
         res.hit = 1'b1;
         res.hit_distance = dsat;
         if (!rec_valid || dsat < rec_distance) begin
            res.is_nearest = 1'b1;
            rec_distance = dsat;
            rec_id = s.object_id;
            rec_valid = 1'b1;
         end
      end
      res.nearest_valid = rec_valid;
      res.nearest_id = rec_id;
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      mismatch_count++;
      $display("mismatch on response %0d: %s got %0h expected %0h",
               results_seen, field, got, want);
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // Response side: random stalls with stretches of constant readiness.
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ($urandom_range(199) == 0) ready_always = !ready_always;
         if (ready_always) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            hold = pick_gap();
            if (hold == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat (hold - 1) @(posedge clock);
               @(posedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // Compares each accepted response with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_hits.size() == 0) begin
            report_mismatch("response with nothing pending", 1, 0);
         end else begin
            want = expected_hits.pop_front();
            if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
            if (got.root_count !== want.root_count)
               report_mismatch("root_count", got.root_count, want.root_count);
            if (got.hit_distance !== want.hit_distance)
               report_mismatch("hit_distance", got.hit_distance, want.hit_distance);
            if (got.is_nearest !== want.is_nearest)
               report_mismatch("is_nearest", got.is_nearest, want.is_nearest);
            if (got.nearest_valid !== want.nearest_valid)
               report_mismatch("nearest_valid", got.nearest_valid, want.nearest_valid);
            if (got.nearest_id !== want.nearest_id)
               report_mismatch("nearest_id", got.nearest_id, want.nearest_id);
            if (want.hit) hits_seen++;
            if (want.root_count == 2'd1) tangents_seen++;
         end
         results_seen++;
      end
   end

   // Sends one request; valid stays high across back-to-back requests.
   task automatic send_request(req_type s);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.data  <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_hits = {expected_hits, trace_sphere(s)};
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // One register write per clock; the caller drops the write enable after the last one.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_ORIGIN_X: ray_org_x = value;
         REG_ORIGIN_Y: ray_org_y = value;
         REG_ORIGIN_Z: ray_org_z = value;
         REG_DIR_X:    ray_dir_x = value[15:0];
         REG_DIR_Y:    ray_dir_y = value[15:0];
         REG_DIR_Z:    ray_dir_z = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_ray(logic signed [31:0] ox, oy, oz, logic signed [15:0] dx, dy, dz);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ORIGIN_Z, oz);
      write_reg(REG_DIR_X, {{16{dx[15]}}, dx});
      write_reg(REG_DIR_Y, {{16{dy[15]}}, dy});
      write_reg(REG_DIR_Z, {{16{dz[15]}}, dz});
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_sphere(logic [15:0] id, longint cx, cy, cz,
                                           logic [30:0] radius);
      req_type s;
      s.kind = KIND_TEST;
      s.object_id = id;
      s.center_x = cx[31:0];
      s.center_y = cy[31:0];
      s.center_z = cz[31:0];
      s.sphere_radius = radius;
      return s;
   endfunction

   function automatic req_type clear_request();
      req_type s;
      s = '0;
      s.kind = KIND_CLEAR;
      s.object_id = 16'($urandom);
      return s;
   endfunction

   // A sphere placed near the current ray with random size and offset.
   function automatic req_type aimed_sphere();
      longint t, jx, jy, jz, span;
      span = (1 << $urandom_range(4, 26));
      t = $urandom_range(0, 3) == 0 ? -longint'($urandom_range(0, 200)) * 65536
                                    : longint'($urandom_range(0, 2000)) * 65536;
      jx = longint'($urandom % span) - span / 2;
      jy = longint'($urandom % span) - span / 2;
      jz = longint'($urandom % span) - span / 2;
      return make_sphere(16'($urandom),
         longint'(ray_org_x) + ((longint'(ray_dir_x) * t) >>> DIR_FRAC) + jx,
         longint'(ray_org_y) + ((longint'(ray_dir_y) * t) >>> DIR_FRAC) + jy,
         longint'(ray_org_z) + ((longint'(ray_dir_z) * t) >>> DIR_FRAC) + jz,
         31'($urandom % (span * 2 + 1)));
   endfunction

   function automatic req_type noise_sphere();
      req_type s;
      s = make_sphere(16'($urandom), longint'($signed($urandom)),
                      longint'($signed($urandom)), longint'($signed($urandom)),
                      31'($urandom));
      return s;
   endfunction

   // Extremes, tangent, behind, zero distance, equal distance and saturation.
   task automatic test_directed_cases();
      longint five;
      five = 5 * 65536;
      set_ray(32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, -DIR_ONE);
      send_request(make_sphere(16'd1, 0, 0, -five, 31'd0));
      send_request(make_sphere(16'd2, 0, 0, five, 31'd65536));
      send_request(make_sphere(16'd3, 0, 0, -65536, 31'd65536));
      send_request(make_sphere(16'd4, 0, 0, -five, 31'd65536));
      send_request(make_sphere(16'd5, 0, 0, -five, 31'd65536));
      send_request(make_sphere(16'hFFFF, 0, 0, 0, 31'd0));
      send_request(make_sphere(16'd6, 0, five, -five, 31'd65536));
      send_request(clear_request());
      send_request(make_sphere(16'd7, 0, 0, five, 31'd65536));
      send_request(make_sphere(16'd8, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                               31'h7FFFFFFF));
      send_request(make_sphere(16'd9, -32'sh80000000, -32'sh80000000, -32'sh80000000,
                               31'h7FFFFFFF));
      send_request(clear_request());
      wait_idle();
      // Far origin and extreme, non-unit direction: distances saturate.
      set_ray(32'sh7FFFFFFF, -32'sh80000000, 32'sh7FFFFFFF,
              16'sh7FFF, -16'sh8000, -16'sh8000);
      send_request(make_sphere(16'd10, -32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000,
                               31'd0));
      send_request(make_sphere(16'd11, -32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000,
                               31'h7FFFFFFF));
      send_request(make_sphere(16'd12, 32'sh7FFFFFFF, -32'sh80000000, 32'sh7FFFFFFF,
                               31'h7FFFFFFF));
      send_request(make_sphere(16'd13, 0, 0, 0, 31'h40000000));
      send_request(make_sphere(16'd14, 0, 0, 0, 31'h40000000));
      wait_idle();
   endtask

   // Random phases, each setting a ray; mostly aimed spheres.
   task automatic test_random_spheres(int count);
      int roll;
      req_type s;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: set_ray($signed($urandom_range(0, 2000) * 65536 - 1000 * 65536), 0, 0,
                       16'sd0, 16'sd0, DIR_ONE);
            1: set_ray(0, $signed($urandom), 0, -DIR_ONE, 16'sd0, 16'sd0);
            2: set_ray($signed($urandom), $signed($urandom), $signed($urandom),
                       $signed(16'($urandom)), $signed(16'($urandom)),
                       $signed(16'($urandom)));
            default: set_ray(0, 0, 0, 16'sd9459, 16'sd9459, -16'sd9459);
         endcase
         for (int n = 0; n < count / 8; n++) begin
            roll = $urandom_range(99);
            if (roll < 6) s = clear_request();
            else if (roll < 16) s = noise_sphere();
            else s = aimed_sphere();
            send_request(s);
         end
         wait_idle();
      end
   endtask

   // The sender stops and lets every response drain before going on.
   task automatic test_drain_pause();
      for (int n = 0; n < 20; n++) send_request(aimed_sphere());
      wait_idle();
      for (int n = 0; n < 20; n++) send_request(aimed_sphere());
      wait_idle();
   endtask

   initial begin
      ray_org_x = '0; ray_org_y = '0; ray_org_z = '0;
      ray_dir_x = '0; ray_dir_y = '0; ray_dir_z = -DIR_ONE;
      rec_distance = '0; rec_valid = 1'b0; rec_id = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_drain_pause();
      test_random_spheres(1600);
      wait_idle();
      $display("Run covered %0d responses: %0d hits and %0d tangent cases,",
               results_seen, hits_seen, tangents_seen);
      $display("over eight ray settings plus the register extremes.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
